// File: hw/rtl/fat_cluster_chain_extents_unit_assert.svh
// Assertion macros for the FAT cluster chain extent unit.
// Depends on nothing; included by the port checker only.
`ifndef FAT_CLUSTER_CHAIN_EXTENTS_UNIT_ASSERT_SVH
`define FAT_CLUSTER_CHAIN_EXTENTS_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FCCE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FCCE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/fcce_pkg.sv
// Shared types and constants of the FAT cluster chain extent unit.
// Depends on nothing; imported by every module of the block.
package fcce_pkg;

    localparam int TABLE_DEPTH = 4096;
    localparam int MAX_EXTENTS = 63;
    localparam int TBL_AW      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(MAX_EXTENTS + 1);

    localparam int CQ_DEPTH = 2;
    localparam int CQ_AW    = $clog2(CQ_DEPTH);
    localparam int RQ_DEPTH = 4;
    localparam int RQ_AW    = $clog2(RQ_DEPTH);

    localparam logic [31:0] ENTRY_MASK = 32'h0FFF_FFFF;

    // Result status codes.
    localparam logic [2:0] ST_EXTENT   = 3'd0;
    localparam logic [2:0] ST_COMPLETE = 3'd1;
    localparam logic [2:0] ST_EARLY    = 3'd2;
    localparam logic [2:0] ST_REJECTED = 3'd3;
    localparam logic [2:0] ST_CAP      = 3'd4;
    localparam logic [2:0] ST_LOADED   = 3'd5;

    // Input command codes.
    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_RESOLVE = 1'b1;

    // Configuration register indexes.
    localparam logic [1:0] CFG_DATA_OFFSET   = 2'd0;
    localparam logic [1:0] CFG_CLUSTER_BYTES = 2'd1;
    localparam logic [1:0] CFG_ENTRY_COUNT   = 2'd2;
    localparam logic [1:0] CFG_END_MARKER    = 2'd3;

    typedef enum logic [1:0] {
        K_LOAD   = 2'd0,
        K_REJECT = 2'd1,
        K_WALK   = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [11:0] index;
        logic [27:0] value;
        logic [27:0] start;
        logic [31:0] size;
    } t_cmd;

    typedef struct packed {
        logic [39:0] data_offset;
        logic [19:0] cluster_bytes;
        logic [12:0] entry_count;
        logic [27:0] end_marker;
    } t_cfg;

    typedef struct packed {
        logic [2:0]  status;
        logic [47:0] byte_offset;
        logic [19:0] byte_count;
        logic [27:0] next_cluster;
        logic [31:0] remaining_bytes;
        logic        last;
    } t_result;

    // Handshake between the walker and the result queue.
    typedef struct packed {
        logic    push;
        t_result data;
    } t_res_req;

endpackage

// File: hw/rtl/fcce_front.sv
// Front end: accepts input words, classifies them and queues commands.
// Depends on fcce_pkg.
module fcce_front
    import fcce_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic        i_command,
    input  logic [11:0] i_entry_index,
    input  logic [31:0] i_entry_value,
    input  logic [27:0] i_start_cluster,
    input  logic [31:0] i_file_size,
    input  logic        i_is_directory,
    output logic        o_cmd_valid,
    output t_cmd        o_cmd,
    input  logic        i_cmd_pop
);

    t_cmd             r_q [CQ_DEPTH];
    logic [CQ_AW-1:0] r_wp, n_wp;
    logic [CQ_AW-1:0] r_rp, n_rp;
    logic [CQ_AW:0]   r_cnt, n_cnt;
    t_cmd             w_cmd;
    logic             w_push;
    logic             w_pop;

    // Classify the word before it enters the queue.
    always_comb begin
        w_cmd.index = i_entry_index;
        w_cmd.value = i_entry_value[27:0];
        w_cmd.start = i_start_cluster;
        w_cmd.size  = i_file_size;
        if (i_command == CMD_LOAD) begin
            w_cmd.kind = K_LOAD;
        end else if (i_is_directory || (i_file_size == 32'd0) || (i_start_cluster < 28'd2)) begin
            w_cmd.kind = K_REJECT;
        end else begin
            w_cmd.kind = K_WALK;
        end
    end

    assign o_full      = (r_cnt == (CQ_AW + 1)'(CQ_DEPTH));
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rp];
    assign w_push      = i_push && !o_full;
    assign w_pop       = i_cmd_pop && o_cmd_valid;

    always_comb begin
        n_wp  = w_push ? CQ_AW'(r_wp + 1'b1) : r_wp;
        n_rp  = w_pop ? CQ_AW'(r_rp + 1'b1) : r_rp;
        n_cnt = r_cnt;
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!w_push && w_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
    end

endmodule

// File: hw/rtl/fcce_walk.sv
// Back end: holds the allocation table, performs loads and walks chains.
// Depends on fcce_pkg.
module fcce_walk
    import fcce_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cfg     i_cfg,
    input  logic     i_cmd_valid,
    input  t_cmd     i_cmd,
    output logic     o_cmd_pop,
    output t_res_req o_res,
    input  logic     i_res_full
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_CHECK = 3'b010,
        S_EMIT  = 3'b100
    } t_state;

    localparam logic [27:0] DEPTH_W = 28'(TABLE_DEPTH);

    t_state           r_state, n_state;
    logic [27:0]      r_cluster, n_cluster;
    logic [31:0]      r_rem, n_rem;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [47:0]      r_prod, n_prod;
    logic [19:0]      r_take, n_take;
    logic             r_in_tbl, n_in_tbl;

    logic [27:0]      r_tbl [TABLE_DEPTH];
    logic [27:0]      r_rdata;
    logic             w_we;
    logic             w_re;
    logic [47:0]      w_prod;
    logic             w_run;

    // The loop keeps going while bytes remain, the cluster is a data cluster
    // and the extent cap has not been reached.
    assign w_run = (r_rem != 32'd0) && (r_cluster >= 28'd2) &&
                   (r_cluster < i_cfg.end_marker) && (r_cnt < CNT_W'(MAX_EXTENTS));
    assign w_prod = {20'd0, r_cluster - 28'd2} * {28'd0, i_cfg.cluster_bytes};

    always_comb begin
        n_state   = r_state;
        n_cluster = r_cluster;
        n_rem     = r_rem;
        n_cnt     = r_cnt;
        n_prod    = r_prod;
        n_take    = r_take;
        n_in_tbl  = r_in_tbl;
        o_cmd_pop = 1'b0;
        o_res     = '0;
        w_we      = 1'b0;
        w_re      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid && !i_res_full) begin
                    o_cmd_pop = 1'b1;
                    unique case (i_cmd.kind)
                        K_LOAD: begin
                            w_we                 = (32'(i_cmd.index) < 32'(TABLE_DEPTH));
                            o_res.push           = 1'b1;
                            o_res.data.status    = ST_LOADED;
                            o_res.data.last      = 1'b1;
                        end
                        K_REJECT: begin
                            o_res.push                 = 1'b1;
                            o_res.data.status          = ST_REJECTED;
                            o_res.data.next_cluster    = i_cmd.start;
                            o_res.data.remaining_bytes = i_cmd.size;
                            o_res.data.last            = 1'b1;
                        end
                        K_WALK: begin
                            n_cluster = i_cmd.start;
                            n_rem     = i_cmd.size;
                            n_cnt     = '0;
                            n_state   = S_CHECK;
                        end
                        default: begin
                            o_cmd_pop = 1'b1;
                        end
                    endcase
                end
            end
            S_CHECK: begin
                if (w_run) begin
                    w_re     = 1'b1;
                    n_prod   = w_prod;
                    n_take   = (r_rem < 32'(i_cfg.cluster_bytes)) ? r_rem[19:0]
                                                                   : i_cfg.cluster_bytes;
                    n_in_tbl = (r_cluster < 28'(i_cfg.entry_count)) && (r_cluster < DEPTH_W);
                    n_state  = S_EMIT;
                end else if (!i_res_full) begin
                    o_res.push                 = 1'b1;
                    o_res.data.next_cluster    = r_cluster;
                    o_res.data.remaining_bytes = r_rem;
                    o_res.data.last            = 1'b1;
                    if (r_rem == 32'd0) begin
                        o_res.data.status = ST_COMPLETE;
                    end else if ((r_cluster >= 28'd2) && (r_cluster < i_cfg.end_marker)) begin
                        o_res.data.status = ST_CAP;
                    end else begin
                        o_res.data.status = ST_EARLY;
                    end
                    n_state = S_IDLE;
                end
            end
            S_EMIT: begin
                if (!i_res_full) begin
                    o_res.push                 = 1'b1;
                    o_res.data.status          = ST_EXTENT;
                    o_res.data.byte_offset     = {8'd0, i_cfg.data_offset} + r_prod;
                    o_res.data.byte_count      = r_take;
                    o_res.data.next_cluster    = r_cluster;
                    o_res.data.remaining_bytes = r_rem - 32'(r_take);
                    n_rem     = r_rem - 32'(r_take);
                    n_cluster = r_in_tbl ? r_rdata : i_cfg.end_marker;
                    n_cnt     = r_cnt + 1'b1;
                    n_state   = S_CHECK;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cluster <= n_cluster;
        r_rem     <= n_rem;
        r_cnt     <= n_cnt;
        r_prod    <= n_prod;
        r_take    <= n_take;
        r_in_tbl  <= n_in_tbl;
    end

    // Allocation table: one write or one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_tbl[TBL_AW'(i_cmd.index)] <= i_cmd.value;
        end
        if (w_re) begin
            r_rdata <= r_tbl[TBL_AW'(r_cluster)];
        end
    end

endmodule

// File: hw/rtl/fcce_rfifo.sv
// Result queue between the chain walker and the output port.
// Depends on fcce_pkg.
module fcce_rfifo
    import fcce_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_res_req i_req,
    output logic     o_full,
    output logic     o_empty,
    output t_result  o_data,
    input  logic     i_pop
);

    t_result          r_q [RQ_DEPTH];
    logic [RQ_AW-1:0] r_wp;
    logic [RQ_AW-1:0] r_rp;
    logic [RQ_AW:0]   r_cnt, n_cnt;
    logic             w_push;
    logic             w_pop;

    assign o_full  = (r_cnt == (RQ_AW + 1)'(RQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_q[r_rp];
    assign w_push  = i_req.push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_comb begin
        n_cnt = r_cnt;
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!w_push && w_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= RQ_AW'(r_wp + 1'b1);
            end
            if (w_pop) begin
                r_rp <= RQ_AW'(r_rp + 1'b1);
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= i_req.data;
        end
    end

endmodule

// File: hw/rtl/fat_cluster_chain_extents_unit.sv
// Top level of the FAT cluster chain extent unit: configuration registers,
// front end, chain walker and result queue. Depends on fcce_pkg,
// fcce_front, fcce_walk and fcce_rfifo.
//
//   Channel   Handshake              Payload
//   -------   --------------------   -------------------------------------------
//   input     push / full            command, entry_index, entry_value,
//                                    start_cluster, file_size, is_directory
//   result    pop / empty            status, byte_offset, byte_count,
//                                    next_cluster, remaining_bytes, last
//   config    i_cfg_we               i_cfg_idx (register), i_cfg_data (40 bits)
//
// A table load or a rejected request is handled in the walker's idle state. A
// resolve is dispatched from the idle state, then each cluster walked passes
// through a check state (table read and offset multiply) and an emit state
// (offset add and emit), and a final check writes the closing word; the
// data of the registered table read names the next cluster.
// Reset is synchronous; it clears the queues and the walker state and sets
// the registers to defaults. The allocation table is not cleared and needs
// no clearing pass. Either side may stall independently: the command queue and
// the result queue decouple the front end and the walker from their neighbors.
module fat_cluster_chain_extents_unit
    import fcce_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input word.
    input  logic        push,
    output logic        full,
    input  logic        i_command,
    input  logic [11:0] i_entry_index,
    input  logic [31:0] i_entry_value,
    input  logic [27:0] i_start_cluster,
    input  logic [31:0] i_file_size,
    input  logic        i_is_directory,
    // Result word.
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  o_status,
    output logic [47:0] o_byte_offset,
    output logic [19:0] o_byte_count,
    output logic [27:0] o_next_cluster,
    output logic [31:0] o_remaining_bytes,
    output logic        o_last,
    // Configuration writes.
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [39:0] i_cfg_data
);

    t_cfg     r_cfg;
    logic     w_cmd_valid;
    t_cmd     w_cmd;
    logic     w_cmd_pop;
    t_res_req w_res;
    logic     w_res_full;
    t_result  w_out;

    // Configuration registers. Each write keeps only the low bits that the
    // register holds; writes must be issued only while the block is idle, which the block does not check.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.data_offset   <= 40'd0;
            r_cfg.cluster_bytes <= 20'd4096;
            r_cfg.entry_count   <= 13'd0;
            r_cfg.end_marker    <= 28'hFFF_FFF8;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DATA_OFFSET:   r_cfg.data_offset   <= i_cfg_data;
                CFG_CLUSTER_BYTES: r_cfg.cluster_bytes <= i_cfg_data[19:0];
                CFG_ENTRY_COUNT:   r_cfg.entry_count   <= i_cfg_data[12:0];
                CFG_END_MARKER:    r_cfg.end_marker    <= i_cfg_data[27:0];
                default: begin
                end
            endcase
        end
    end

    // The front end sorts each word into a load, a reject or a walk.
    fcce_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (push),
        .o_full          (full),
        .i_command       (i_command),
        .i_entry_index   (i_entry_index),
        .i_entry_value   (i_entry_value),
        .i_start_cluster (i_start_cluster),
        .i_file_size     (i_file_size),
        .i_is_directory  (i_is_directory),
        .o_cmd_valid     (w_cmd_valid),
        .o_cmd           (w_cmd),
        .i_cmd_pop       (w_cmd_pop)
    );

    // The walker owns the allocation table and produces every result word.
    fcce_walk u_walk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_pop   (w_cmd_pop),
        .o_res       (w_res),
        .i_res_full  (w_res_full)
    );

    // Results wait here until the consumer pops them.
    fcce_rfifo u_rfifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_res),
        .o_full  (w_res_full),
        .o_empty (empty),
        .o_data  (w_out),
        .i_pop   (pop)
    );

    assign o_status          = w_out.status;
    assign o_byte_offset     = w_out.byte_offset;
    assign o_byte_count      = w_out.byte_count;
    assign o_next_cluster    = w_out.next_cluster;
    assign o_remaining_bytes = w_out.remaining_bytes;
    assign o_last            = w_out.last;

endmodule

// File: hw/rtl/fcce_checker.sv
// Port-level checker for the FAT cluster chain extent unit and its bind.
// Depends on fat_cluster_chain_extents_unit_assert.svh and the top level.
`include "fat_cluster_chain_extents_unit_assert.svh"

module fcce_checker
    import fcce_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        empty,
    input logic        pop,
    input logic [2:0]  o_status,
    input logic [47:0] o_byte_offset,
    input logic [19:0] o_byte_count,
    input logic [27:0] o_next_cluster,
    input logic [31:0] o_remaining_bytes,
    input logic        o_last
);

    // A waiting result word stays put until it is popped.
    `FCCE_ASSERT_NEXT(a_result_holds, i_clk, i_rst_n, (!empty && !pop), (!empty && $stable(o_status) && $stable(o_byte_offset) && $stable(o_next_cluster) && $stable(o_remaining_bytes)), "result word changed while stalled")

    // Only extents continue a request; every other word closes it.
    `FCCE_ASSERT_NOW(a_last_matches, i_clk, i_rst_n, !empty, (o_last == (o_status != ST_EXTENT)), "last flag does not match status")

    // Closing, rejected and load words carry no extent.
    `FCCE_ASSERT_NOW(a_close_no_extent, i_clk, i_rst_n, (!empty && o_status != ST_EXTENT), (o_byte_offset == 48'd0 && o_byte_count == 20'd0), "closing word carries an extent")

    // A completed walk has located every byte.
    `FCCE_ASSERT_NOW(a_complete_drained, i_clk, i_rst_n, (!empty && o_status == ST_COMPLETE), (o_remaining_bytes == 32'd0), "complete status with bytes left")

endmodule

bind fat_cluster_chain_extents_unit fcce_checker u_fcce_checker (.*);
